FILE: hdl/assert_macros.svh
// Assertion macros for the checker file wdb_chk.
// All properties sample on the rising edge of clk and are off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: antecedent and consequent in the same cycle.
`define WDB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define WDB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/wdb_pkg.sv
package wdb_pkg;

  localparam int MAX_WATCHDOGS = 16;
  localparam int IDX_W = (MAX_WATCHDOGS > 1) ? $clog2(MAX_WATCHDOGS) : 1;
  localparam int CNT_W = $clog2(MAX_WATCHDOGS + 1);

  localparam logic [15:0] DEFAULT_RELOAD_RST = 16'd100;

  // command codes (in_tuser)
  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_FEED     = 2'd1;
  localparam logic [1:0] CMD_QUERY    = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // result kinds (out_tuser)
  localparam logic [2:0] KIND_REGISTERED = 3'd0;
  localparam logic [2:0] KIND_BANK_FULL  = 3'd1;
  localparam logic [2:0] KIND_FED        = 3'd2;
  localparam logic [2:0] KIND_QUERY      = 3'd3;
  localparam logic [2:0] KIND_EXPIRED    = 3'd4;
  localparam logic [2:0] KIND_DONE       = 3'd5;

  // one watchdog slot
  typedef struct packed {
    logic [15:0] cnt;
    logic [15:0] rld;
    logic [15:0] own;
    logic        hdl;
  } ent_t;

  typedef struct packed {
    logic shift;
    logic load_all;
    logic load_cnt;
  } cell_ctl_t;

endpackage

FILE: hdl/wdb_cell.sv
module wdb_cell (
  input  logic              clk,
  input  wdb_pkg::cell_ctl_t ctl,
  input  wdb_pkg::ent_t     shift_in,
  input  wdb_pkg::ent_t     load_data,
  output wdb_pkg::ent_t     ent
);
  import wdb_pkg::*;

  ent_t ent_r;

  // shift has priority; loads only happen while the ring is at rest
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ent_r <= shift_in;
    end else if (ctl.load_all) begin
      ent_r <= load_data;
    end else if (ctl.load_cnt) begin
      ent_r.cnt <= ent_r.rld;
    end
  end

  assign ent = ent_r;

endmodule

FILE: hdl/watchdog_bank_unit.sv
// Channel | Direction | Handshake            | Payload
// in_     | request   | in_tvalid/in_tready  | tuser command, tdata slot..has_handler
// out_    | result    | out_tvalid/out_tready| tuser kind, tdata slot/owner/online, tlast
// cfg_    | write     | cfg_valid/cfg_ready  | default_reload
//
// Register, feed and query each give one result, which sits in the output register.
// A tick rotates the whole ring once round whatever the fill, then loads done into
// the output register and returns to idle; in_tready stays low until the tick is over.
// A stalled output holds the ring still, so each expiry adds the wait on out_tready.
// rst_n (synchronous) clears slot use, the FSM and default_reload (to 100).
module watchdog_bank_unit (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [55:0] in_tdata,   // [3:0] slot, [19:4] owner_tag, [35:20] reload_value,
                                  // [51:36] initial_value, [52] has_handler, rest zero
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic [23:0] out_tdata,  // [3:0] result_slot, [19:4] result_owner, [20] online
  output logic        out_tlast,  // last
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // default_reload
);
  import wdb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  // request fields
  logic [1:0]  command;
  logic [3:0]  slot;
  logic [15:0] owner_tag;
  logic [15:0] reload_value;
  logic [15:0] initial_value;
  logic        has_handler;

  assign command       = in_tuser;
  assign slot          = in_tdata[3:0];
  assign owner_tag     = in_tdata[19:4];
  assign reload_value  = in_tdata[35:20];
  assign initial_value = in_tdata[51:36];
  assign has_handler   = in_tdata[52];

  logic             state_r;
  logic [CNT_W-1:0] step_r;
  logic [CNT_W-1:0] used_r;
  logic [15:0]      dflt_r;

  logic        out_valid_r;
  logic [2:0]  kind_r;
  logic [3:0]  rslot_r;
  logic [15:0] rowner_r;
  logic        online_r;
  logic        last_r;

  logic out_free;
  logic out_load;
  logic in_acc;
  logic bank_full;
  logic slot_ok;
  logic [7:0] slot8;
  logic [IDX_W-1:0] sel_idx;
  logic [IDX_W-1:0] reg_idx;

  ent_t      ents [MAX_WATCHDOGS];
  cell_ctl_t ctls [MAX_WATCHDOGS];
  ent_t      new_ent;
  ent_t      head_proc;
  logic      head_active;
  logic      head_expire;
  logic      tick_adv;
  logic [15:0] reload_eff;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign bank_full = (used_r == CNT_W'(MAX_WATCHDOGS));
  assign slot8     = 8'(slot);
  assign slot_ok   = slot8 < 8'(used_r);
  assign sel_idx   = slot8[IDX_W-1:0];
  assign reg_idx   = used_r[IDX_W-1:0];

  // registration: zero reload takes the default, zero initial takes the reload
  assign reload_eff   = (reload_value == 16'd0) ? dflt_r : reload_value;
  assign new_ent.cnt  = (initial_value == 16'd0) ? reload_eff : initial_value;
  assign new_ent.rld  = reload_eff;
  assign new_ent.own  = owner_tag;
  assign new_ent.hdl  = has_handler;

  // head of the ring (cell 0) holds slot step_r during a tick
  assign head_active = step_r < used_r;
  assign head_expire = head_active && (ents[0].cnt == 16'd0) && ents[0].hdl;
  assign tick_adv    = (state_r == ST_TICK) && out_free &&
                       (step_r != CNT_W'(MAX_WATCHDOGS));

  // a new result enters the output register: any non-tick request, an expiry
  // at the head, or the closing done of a tick
  assign out_load = (in_acc && (command != CMD_TICK)) ||
                    ((state_r == ST_TICK) && out_free &&
                     ((step_r == CNT_W'(MAX_WATCHDOGS)) || head_expire));

  always_comb begin
    head_proc = ents[0];
    if (head_active && ents[0].cnt != 16'd0) begin
      head_proc.cnt = ents[0].cnt - 16'd1;
    end
  end

  // ring of cells: each hands its slot to the one below, the head wraps to the tail
  genvar k;
  generate
    for (k = 0; k < MAX_WATCHDOGS; k++) begin : g_cell
      assign ctls[k].shift    = tick_adv;
      assign ctls[k].load_all = in_acc && (command == CMD_REGISTER) && !bank_full &&
                                (reg_idx == IDX_W'(k));
      assign ctls[k].load_cnt = in_acc && (command == CMD_FEED) && slot_ok &&
                                (sel_idx == IDX_W'(k));
      if (k == MAX_WATCHDOGS - 1) begin : g_tail
        wdb_cell u_cell (
          .clk       (clk),
          .ctl       (ctls[k]),
          .shift_in  (head_proc),
          .load_data (new_ent),
          .ent       (ents[k])
        );
      end else begin : g_body
        wdb_cell u_cell (
          .clk       (clk),
          .ctl       (ctls[k]),
          .shift_in  (ents[k+1]),
          .load_data (new_ent),
          .ent       (ents[k])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      used_r      <= '0;
      dflt_r      <= DEFAULT_RELOAD_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dflt_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            rowner_r <= 16'd0;
            last_r   <= 1'b1;
            case (command)
              CMD_REGISTER: begin
                online_r <= 1'b0;
                if (bank_full) begin
                  kind_r  <= KIND_BANK_FULL;
                  rslot_r <= 4'd0;
                end else begin
                  kind_r  <= KIND_REGISTERED;
                  rslot_r <= 4'(used_r);
                  used_r  <= used_r + CNT_W'(1);
                end
              end
              CMD_FEED: begin
                kind_r   <= KIND_FED;
                rslot_r  <= slot;
                online_r <= 1'b0;
              end
              CMD_QUERY: begin
                kind_r   <= KIND_QUERY;
                rslot_r  <= slot;
                online_r <= slot_ok && (ents[sel_idx].cnt != 16'd0);
              end
              default: begin
                state_r <= ST_TICK;
                step_r  <= '0;
              end
            endcase
          end
        end
        ST_TICK: begin
          if (out_free) begin
            if (step_r == CNT_W'(MAX_WATCHDOGS)) begin
              kind_r      <= KIND_DONE;
              rslot_r     <= 4'd0;
              rowner_r    <= 16'd0;
              online_r    <= 1'b0;
              last_r      <= 1'b1;
              state_r     <= ST_IDLE;
            end else begin
              step_r <= step_r + CNT_W'(1);
              if (head_expire) begin
                kind_r      <= KIND_EXPIRED;
                rslot_r     <= 4'(step_r);
                rowner_r    <= ents[0].own;
                online_r    <= 1'b0;
                last_r      <= 1'b0;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {3'd0, online_r, rowner_r, rslot_r};
  assign out_tlast  = last_r;

endmodule

FILE: hdl/wdb_chk.sv
`include "assert_macros.svh"

module wdb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [2:0]  out_tuser,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  import wdb_pkg::*;

  logic no_payload;

  // done and bank full carry no slot, owner or online
  assign no_payload = (out_tuser == KIND_DONE) || (out_tuser == KIND_BANK_FULL);

  `WDB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `WDB_ASSERT_NOW(a_last_kind, out_tvalid, out_tlast == (out_tuser != KIND_EXPIRED))
  `WDB_ASSERT_NOW(a_empty_fields, out_tvalid && no_payload, out_tdata == 24'd0)
  `WDB_ASSERT_NOW(a_online_query, out_tvalid && out_tdata[20], out_tuser == KIND_QUERY)

endmodule

bind watchdog_bank_unit wdb_chk u_wdb_chk (.*);
